FILE: rtl/rsti_pkg.sv
// Package with payload types, character codes and helpers for the string-to-integer core.
`default_nettype none
package rsti_pkg;

    // Default accumulator width.
    localparam int VALUE_BITS_DEFAULT = 32;

    // Radix register.
    localparam int RADIX_BITS = 6;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;

    // Character codes.
    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_PLUS   = 8'h2b;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_LOW_X  = 8'h78;

    // Position counter.
    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = 16'hffff;

    // Input request: one character of the string.
    typedef struct packed {
        logic [7:0] character;
        logic       first;
    } in_req_t;

    // Output request: one converted number.
    typedef struct packed {
        logic signed [31:0]    value;
        logic [POS_BITS-1:0]   end_offset;
        logic                  overflow;
    } out_req_t;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE        = 4'b0001,
        PH_AFTER_SIGN  = 4'b0010,
        PH_PREFIX_ZERO = 4'b0100,
        PH_DIGITS      = 4'b1000
    } phase_t;

    // Map the register to the base actually used: anything but 2, 8, 16 means 10.
    function automatic logic [RADIX_BITS-1:0] effective_base(input logic [RADIX_BITS-1:0] r);
        logic [RADIX_BITS-1:0] b;
        b = RADIX_DEC;
        if (r == RADIX_BIN || r == RADIX_OCT || r == RADIX_HEX)
        begin
            b = r;
        end
        return b;
    endfunction

    // Digit value of a character; lowercase hex only. Bit 4 is the valid flag.
    function automatic logic [4:0] decode_digit(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] t;
        r = 5'd0;
        t = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            t = c - CHAR_ZERO;
            r = {1'b1, t[3:0]};
        end
        else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
        begin
            t = c - CHAR_LOW_A + 8'd10;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/radix_string_to_integer_core.sv
// Streaming string-to-integer converter: input register, one parse step, result register.
// A terminating character's result passes from the input register through the parse step into the result register.
// Throughput: one character per cycle unless stalled; the Horner step is shifts and at most two adds.
// A result waiting in the result register holds the parse stage, and the input then stalls
// once the input stage is full.
// Reset (rst_n low, asynchronous) empties both stages, clears the parse state to idle
// and sets the radix register to 10.
`default_nettype none
module radix_string_to_integer_core #(
    parameter int VALUE_BITS = rsti_pkg::VALUE_BITS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  rsti_pkg::in_req_t                  in_data,
    output logic                               out_valid,
    input  wire                                out_ready,
    output rsti_pkg::out_req_t                 out_data,
    input  wire                                radix_we,
    input  wire [rsti_pkg::RADIX_BITS-1:0]     radix_wdata
);

    localparam int EXT_BITS = VALUE_BITS + 4;
    localparam int PB = rsti_pkg::POS_BITS;

    // Registers.
    logic [rsti_pkg::RADIX_BITS-1:0] radix_reg;
    logic                            s1_valid_reg;
    rsti_pkg::in_req_t               s1_data_reg;
    rsti_pkg::phase_t                phase_reg, phase_next;
    logic                            neg_reg, neg_next;
    logic [VALUE_BITS-1:0]           acc_reg, acc_next;
    logic [PB-1:0]                   pos_reg, pos_next;
    logic                            wrap_reg, wrap_next;
    logic                            out_valid_reg, out_valid_next;
    rsti_pkg::out_req_t              out_data_reg, out_data_next;

    logic                            s1_fire;
    logic                            emit;
    logic [rsti_pkg::RADIX_BITS-1:0] base;
    logic                            is_hex;
    logic [4:0]                      digit;
    logic                            digit_ok;
    logic [EXT_BITS-1:0]             acc_ext;
    logic [EXT_BITS-1:0]             prod;
    logic [VALUE_BITS-1:0]           mag;
    logic [PB-1:0]                   pos_adv;
    logic [7:0]                      c;

    // Handshake: the parse stage moves when the result register can take a request.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Digit decode and Horner step for the current base.
    assign c        = s1_data_reg.character;
    assign base     = rsti_pkg::effective_base(radix_reg);
    assign is_hex   = (base == rsti_pkg::RADIX_HEX);
    assign digit    = rsti_pkg::decode_digit(c);
    assign digit_ok = digit[4] && ({1'b0, digit[3:0]} < base);

    // One parse step on the registered character.
    always_comb
    begin
        logic try_digit;
        try_digit      = 1'b0;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        wrap_next      = wrap_reg;
        emit           = 1'b0;
        acc_ext        = '0;
        prod           = '0;
        mag            = '0;
        pos_adv        = '0;

        if (s1_data_reg.first)
        begin
            neg_next   = 1'b0;
            acc_next   = '0;
            pos_next   = '0;
            wrap_next  = 1'b0;
            phase_next = rsti_pkg::PH_AFTER_SIGN;
        end

        pos_adv = (pos_next == rsti_pkg::POS_MAX) ? pos_next : pos_next + 1'b1;

        if (s1_data_reg.first && (c == rsti_pkg::CHAR_MINUS || c == rsti_pkg::CHAR_PLUS))
        begin
            neg_next = (c == rsti_pkg::CHAR_MINUS);
            pos_next = pos_adv;
        end
        else
        begin
            case (phase_next)
                rsti_pkg::PH_AFTER_SIGN:
                begin
                    if (is_hex && c == rsti_pkg::CHAR_ZERO)
                    begin
                        pos_next   = pos_adv;
                        phase_next = rsti_pkg::PH_PREFIX_ZERO;
                    end
                    else
                    begin
                        phase_next = rsti_pkg::PH_DIGITS;
                        try_digit  = 1'b1;
                    end
                end
                rsti_pkg::PH_PREFIX_ZERO:
                begin
                    phase_next = rsti_pkg::PH_DIGITS;
                    if (is_hex && c == rsti_pkg::CHAR_LOW_X)
                    begin
                        pos_next = pos_adv;
                    end
                    else
                    begin
                        try_digit = 1'b1;
                    end
                end
                rsti_pkg::PH_DIGITS:
                begin
                    try_digit = 1'b1;
                end
                default:
                begin
                    try_digit = 1'b0;
                end
            endcase
        end

        // Multiply by the base with shifts, then add the digit.
        acc_ext = {4'b0000, acc_next};
        case (base)
            rsti_pkg::RADIX_BIN: prod = acc_ext << 1;
            rsti_pkg::RADIX_OCT: prod = acc_ext << 3;
            rsti_pkg::RADIX_HEX: prod = acc_ext << 4;
            default:             prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
        prod = prod + EXT_BITS'(digit[3:0]);

        if (try_digit)
        begin
            if (digit_ok)
            begin
                if (prod[EXT_BITS-1:VALUE_BITS] != 4'b0000)
                begin
                    wrap_next = 1'b1;
                end
                acc_next = prod[VALUE_BITS-1:0];
                pos_next = pos_adv;
            end
            else
            begin
                emit       = 1'b1;
                phase_next = rsti_pkg::PH_IDLE;
            end
        end

        // Apply the sign; the cast sign-extends or truncates to 32 bits.
        mag = neg_next ? (VALUE_BITS'(0) - acc_next) : acc_next;
        out_data_next.value      = 32'(signed'(mag));
        out_data_next.end_offset = pos_next;
        out_data_next.overflow   = wrap_next;
    end

    // Result register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rsti_pkg::RADIX_RESET;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= rsti_pkg::PH_IDLE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (radix_we)
            begin
                radix_reg <= radix_wdata;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
                wrap_reg  <= wrap_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
`default_nettype wire
